// File: hw/rtl/i2c_master_byte_engine_macros.svh
// assertion macros for the i2c master byte engine
// used by i2cm_seq and i2c_master_byte_engine; no other dependencies
`ifndef I2C_MASTER_BYTE_ENGINE_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define I2CM_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define I2CM_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define I2CM_ASSERT_NOW(name, clk, rst_n, ante, cons, msg)
`define I2CM_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: hw/rtl/i2cm_pkg.sv
// shared types, codes and constants for the i2c master byte engine
// no dependencies; imported by i2cm_seq, i2cm_out_buf and i2c_master_byte_engine
package i2cm_pkg;

    localparam int CFG_W           = 10;
    localparam int DELAY_BITS_DEF  = 10;
    localparam int HALF_PERIOD_RST = 10;
    localparam int BYTE_BITS       = 8;

    // command codes; the two unused codes fall to the default arm
    typedef enum logic [2:0] {
        CMD_NONE      = 3'd0,
        CMD_START     = 3'd1,
        CMD_STOP      = 3'd2,
        CMD_WRITE     = 3'd3,
        CMD_READ_ACK  = 3'd4,
        CMD_READ_NACK = 3'd5
    } cmd_e;

    // start status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_BUSY  = 2'd1,
        STAT_ERROR = 2'd2
    } status_e;

    // bus phases
    typedef enum logic [4:0] {
        PH_IDLE = 5'd0,
        PH_ST_A = 5'd1,
        PH_ST_B = 5'd2,
        PH_ST_C = 5'd3,
        PH_SP_A = 5'd4,
        PH_SP_B = 5'd5,
        PH_SP_C = 5'd6,
        PH_WR_A = 5'd7,
        PH_WR_B = 5'd8,
        PH_WR_C = 5'd9,
        PH_WA_A = 5'd10,
        PH_WA_B = 5'd11,
        PH_WA_C = 5'd12,
        PH_RD_A = 5'd13,
        PH_RD_B = 5'd14,
        PH_RK_A = 5'd15,
        PH_RK_B = 5'd16,
        PH_RK_C = 5'd17,
        PH_RK_D = 5'd18
    } phase_e;

    typedef logic [CFG_W-1:0] half_period_t;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] tx_byte;
        logic       sda_in;
    } cmd_item_t;

    typedef struct packed {
        logic       scl_release;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       acked;
        logic [1:0] status;
    } res_item_t;

endpackage

// File: hw/rtl/i2cm_stream_if.sv
// valid/ready channel with a typed payload
// no dependencies; payload type is set by the instantiating code
interface i2cm_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/i2cm_seq.sv
// bus phase sequencer: state registers and per-tick next-state logic
// depends on i2cm_pkg and i2c_master_byte_engine_macros.svh
`include "i2c_master_byte_engine_macros.svh"

module i2cm_seq #(
    parameter int DELAY_BITS = i2cm_pkg::DELAY_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  i2cm_pkg::cmd_item_t   item,
    input  logic [DELAY_BITS-1:0] limit,
    output i2cm_pkg::res_item_t   result
);
    import i2cm_pkg::*;

    phase_e                phase_reg, phase_next;
    logic [3:0]            bit_count_reg, bit_count_next;
    logic [DELAY_BITS-1:0] tick_reg, tick_next;
    logic [7:0]            shreg_reg, shreg_next;
    logic                  nack_reg, nack_next;
    logic                  scl_reg, scl_next;
    logic                  sda_reg, sda_next;
    logic [1:0]            status_reg, status_next;
    logic                  ack_reg, ack_next;
    logic [7:0]            rx_reg, rx_next;

    logic                  enter;
    logic                  finish;
    logic                  phase_end;
    logic [DELAY_BITS-1:0] tick_inc;
    logic [3:0]            bc_inc;
    logic                  byte_full;
    logic [7:0]            shift_in;

    // tick and bit counting
    assign tick_inc  = tick_reg + DELAY_BITS'(1);
    assign phase_end = (phase_reg != PH_IDLE) && (tick_inc >= limit);
    assign bc_inc    = bit_count_reg + 4'd1;
    assign byte_full = bc_inc >= 4'(BYTE_BITS);
    assign shift_in  = {shreg_reg[6:0], item.sda_in};

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        enter      = 1'b0;
        finish     = 1'b0;
        if (phase_reg == PH_IDLE)
        begin
            enter = 1'b1;
            case (item.command)
                CMD_START:     phase_next = PH_ST_A;
                CMD_STOP:      phase_next = PH_SP_A;
                CMD_WRITE:     phase_next = PH_WR_A;
                CMD_READ_ACK:  phase_next = PH_RD_A;
                CMD_READ_NACK: phase_next = PH_RD_A;
                default:       enter = 1'b0;
            endcase
        end
        else if (phase_end)
        begin
            enter = 1'b1;
            case (phase_reg)
                PH_ST_A:
                begin
                    if (item.sda_in)
                        phase_next = PH_ST_B;
                    else
                    begin
                        enter  = 1'b0;
                        finish = 1'b1;
                    end
                end
                PH_ST_B:
                begin
                    if (!item.sda_in)
                        phase_next = PH_ST_C;
                    else
                    begin
                        enter  = 1'b0;
                        finish = 1'b1;
                    end
                end
                PH_SP_A: phase_next = PH_SP_B;
                PH_SP_B: phase_next = PH_SP_C;
                PH_WR_A: phase_next = PH_WR_B;
                PH_WR_B: phase_next = PH_WR_C;
                PH_WR_C: phase_next = byte_full ? PH_WA_A : PH_WR_A;
                PH_WA_A: phase_next = PH_WA_B;
                PH_WA_B: phase_next = PH_WA_C;
                PH_RD_A: phase_next = PH_RD_B;
                PH_RD_B: phase_next = byte_full ? PH_RK_A : PH_RD_A;
                PH_RK_A: phase_next = PH_RK_B;
                PH_RK_B: phase_next = PH_RK_C;
                PH_RK_C: phase_next = PH_RK_D;
                default:
                begin
                    // end of start, stop, write ack and read ack phases
                    enter  = 1'b0;
                    finish = 1'b1;
                end
            endcase
            if (finish)
                phase_next = PH_IDLE;
        end
    end

    // counters, shifter, flags and line drive
    always_comb
    begin
        tick_next      = (enter || finish) ? '0 : ((phase_reg == PH_IDLE) ? tick_reg : tick_inc);
        bit_count_next = bit_count_reg;
        shreg_next     = shreg_reg;
        nack_next      = nack_reg;
        status_next    = status_reg;
        ack_next       = ack_reg;
        rx_next        = rx_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;

        // command accept
        if (phase_reg == PH_IDLE && enter)
        begin
            bit_count_next = '0;
            nack_next      = item.command == CMD_READ_NACK;
            shreg_next     = (item.command == CMD_WRITE) ? item.tx_byte : 8'd0;
        end

        // work done at the end of a phase
        if (phase_end)
        begin
            case (phase_reg)
                PH_ST_A: if (!item.sda_in) status_next = STAT_BUSY;
                PH_ST_B: if (item.sda_in) status_next = STAT_ERROR;
                PH_ST_C: status_next = STAT_OK;
                PH_WR_B: shreg_next = {shreg_reg[6:0], 1'b0};
                PH_WR_C: bit_count_next = bc_inc;
                PH_WA_C:
                begin
                    ack_next = !item.sda_in;
                    scl_next = 1'b0;
                end
                PH_RD_B:
                begin
                    shreg_next     = shift_in;
                    bit_count_next = bc_inc;
                    if (byte_full)
                        rx_next = shift_in;
                end
                default: ;
            endcase
        end

        // line changes on phase entry
        if (enter)
        begin
            case (phase_next)
                PH_ST_A:
                begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                end
                PH_ST_B: sda_next = 1'b0;
                PH_ST_C: scl_next = 1'b0;
                PH_SP_A:
                begin
                    scl_next = 1'b0;
                    sda_next = 1'b0;
                end
                PH_SP_B: scl_next = 1'b1;
                PH_SP_C: sda_next = 1'b1;
                PH_WR_A: scl_next = 1'b0;
                PH_WR_B: sda_next = shreg_reg[7];
                PH_WR_C: scl_next = 1'b1;
                PH_WA_A: scl_next = 1'b0;
                PH_WA_B: sda_next = 1'b1;
                PH_WA_C: scl_next = 1'b1;
                PH_RD_A:
                begin
                    scl_next = 1'b0;
                    sda_next = 1'b1;
                end
                PH_RD_B: scl_next = 1'b1;
                PH_RK_A: scl_next = 1'b0;
                PH_RK_B: sda_next = nack_reg;
                PH_RK_C: scl_next = 1'b1;
                PH_RK_D: scl_next = 1'b0;
                default: ;
            endcase
        end
    end

    // result of this tick
    always_comb
    begin
        result.scl_release = scl_next;
        result.sda_release = sda_next;
        result.busy_res    = phase_next != PH_IDLE;
        result.done_res    = finish;
        result.rx_byte     = rx_next;
        result.acked       = ack_next;
        result.status      = status_next;
    end

    // state registers, one update per advanced tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            bit_count_reg <= '0;
            tick_reg      <= '0;
            shreg_reg     <= '0;
            nack_reg      <= 1'b0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            status_reg    <= STAT_OK;
            ack_reg       <= 1'b0;
            rx_reg        <= '0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            bit_count_reg <= bit_count_next;
            tick_reg      <= tick_next;
            shreg_reg     <= shreg_next;
            nack_reg      <= nack_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            status_reg    <= status_next;
            ack_reg       <= ack_next;
            rx_reg        <= rx_next;
        end
    end

    // checks
    `I2CM_ASSERT_NEXT(a_finish_to_idle, clk, rst_n, step && finish, phase_reg == PH_IDLE, "finished command did not return to idle")
    `I2CM_ASSERT_NEXT(a_phase_holds, clk, rst_n, step && (phase_reg != PH_IDLE) && !phase_end, $stable(phase_reg), "phase left before its last tick")
    `I2CM_ASSERT_NOW(a_bit_range, clk, rst_n, 1'b1, bit_count_reg <= 4'(BYTE_BITS), "bit count beyond one byte")

endmodule

// File: hw/rtl/i2cm_out_buf.sv
// result register with valid/ready handshake toward the consumer
// depends on i2cm_pkg and i2cm_stream_if
module i2cm_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  i2cm_pkg::res_item_t item,
    output logic                can_load,
    i2cm_stream_if.source       res
);
    import i2cm_pkg::*;

    logic      valid_reg;
    res_item_t data_reg;

    // free when empty or when the held result leaves this cycle
    assign can_load  = !valid_reg || res.ready;
    assign res.valid = valid_reg;
    assign res.data  = data_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (res.ready)
            valid_reg <= 1'b0;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= item;
    end

endmodule

// File: hw/rtl/i2c_master_byte_engine.sv
// top level of the i2c master byte engine: input register, config, sequencer, result register
// depends on i2cm_pkg, i2cm_stream_if, i2cm_seq, i2cm_out_buf and the macros header
//
// channel | dir | payload                                           | accepted when
// cmd     | in  | command, tx_byte, sda_in                          | valid && ready
// res     | out | scl_release, sda_release, busy_res, done_res,     | valid && ready
//         |     | rx_byte, acked, status                            |
// cfg     | in  | half_period_ticks                                 | valid && ready
//
// one tick per cycle while res is not stalled: a tick is held in the input register, and when it
// advances the sequencer updates its state and loads the result register
// res valid rises after the cmd item passes the input register and then the result register; cfg is always ready
// a stalled res channel holds the result register and then the input register
// reset returns to idle with both lines released and the half period set to 10 ticks
`include "i2c_master_byte_engine_macros.svh"

module i2c_master_byte_engine #(
    parameter int DELAY_BITS = i2cm_pkg::DELAY_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    i2cm_stream_if.sink   cmd,
    i2cm_stream_if.source res,
    i2cm_stream_if.sink   cfg
);
    import i2cm_pkg::*;

    localparam int LW      = (DELAY_BITS > CFG_W) ? DELAY_BITS : CFG_W;
    localparam int CAP     = (1 << DELAY_BITS) - 1;
    localparam int LIM_RST = (HALF_PERIOD_RST > CAP) ? CAP : HALF_PERIOD_RST;
    localparam logic [LW-1:0] CAP_W = LW'(CAP);

    logic                  in_valid_reg;
    cmd_item_t             in_item_reg;
    logic                  advance;
    logic                  out_free;
    res_item_t             seq_res;
    logic [DELAY_BITS-1:0] limit_reg, limit_next;
    logic [LW-1:0]         hp_wide;
    logic [LW-1:0]         hp_sat;

    // pipeline flow
    assign advance   = in_valid_reg && out_free;
    assign cmd.ready = !in_valid_reg || advance;
    assign cfg.ready = 1'b1;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (cmd.valid && cmd.ready)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
            in_item_reg <= cmd.data;
    end

    // phase length: held to the counter range, zero taken as one tick
    always_comb
    begin
        hp_wide    = LW'(cfg.data);
        hp_sat     = (hp_wide > CAP_W) ? CAP_W : hp_wide;
        limit_next = (hp_sat == '0) ? DELAY_BITS'(1) : hp_sat[DELAY_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= DELAY_BITS'(LIM_RST);
        else if (cfg.valid && cfg.ready)
            limit_reg <= limit_next;
    end

    // sequencer
    i2cm_seq #(
        .DELAY_BITS (DELAY_BITS)
    ) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .limit  (limit_reg),
        .result (seq_res)
    );

    // result register
    i2cm_out_buf u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .item     (seq_res),
        .can_load (out_free),
        .res      (res)
    );

    // checks
    `I2CM_ASSERT_NEXT(a_adv_gives_result, clk, rst_n, advance, res.valid, "advanced tick produced no result")
    `I2CM_ASSERT_NEXT(a_in_held, clk, rst_n, in_valid_reg && !advance, in_valid_reg && $stable(in_item_reg), "stalled tick lost or changed")
    `I2CM_ASSERT_NEXT(a_limit_nonzero, clk, rst_n, cfg.valid && cfg.ready, limit_reg != '0, "phase length written as zero")

endmodule
